// File: hdl/slcf_pkg.sv
// shared types and constants of the sync/length/checksum frame receiver
// no dependencies; imported by the interfaces and every module but slcf_ram

package slcf_pkg;

    localparam int BYTE_W        = 8;
    localparam int PAYLOAD_DEPTH = 64;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
    localparam int LEN_W         = 6;
    localparam int LIMIT_W       = 7;

    localparam logic [BYTE_W-1:0]  SYNC_FIRST_RST   = 8'hAA;
    localparam logic [BYTE_W-1:0]  SYNC_SECOND_RST  = 8'hAF;
    localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RST = 7'd50;
    localparam logic [BYTE_W-1:0]  FUNC_MAX_EXCL    = 8'hF1;

    // lengths are 6 bits and must fit the store
    localparam logic [LIMIT_W-1:0] LIMIT_CAP =
        LIMIT_W'((PAYLOAD_DEPTH < 64) ? PAYLOAD_DEPTH : 64);

    // register indexes on the apb port
    localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
    localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_FUNC,
        PH_LEN,
        PH_DATA,
        PH_SUM
    } phase_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_LOAD,
        EM_FLAG
    } emit_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  sync_first;
        logic [BYTE_W-1:0]  sync_second;
        logic [LIMIT_W-1:0] length_limit;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              valid;
        logic              flagged;
        logic              sum_ok;
        logic [BYTE_W-1:0] func;
        logic [LEN_W-1:0]  len;
    } frame_start_t;

    typedef struct packed {
        logic [BYTE_W-1:0] func_code;
        logic [LEN_W-1:0]  payload_len;
        logic [LEN_W-1:0]  byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic              has_byte;
        logic              sum_ok;
        logic              last;
    } result_t;

endpackage

// File: hdl/slcf_in_if.sv
// received byte channel: valid/ready handshake with one byte of payload
// depends on slcf_pkg

interface slcf_in_if;
    import slcf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hdl/slcf_out_if.sv
// result channel: valid/ready handshake carrying one frame result
// depends on slcf_pkg

interface slcf_out_if;
    import slcf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] func_code;
    logic [LEN_W-1:0]  payload_len;
    logic [LEN_W-1:0]  byte_index;
    logic [BYTE_W-1:0] byte_value;
    logic              has_byte;
    logic              sum_ok;
    logic              last;

    modport source (
        output valid, output func_code, output payload_len, output byte_index,
        output byte_value, output has_byte, output sum_ok, output last,
        input ready
    );
    modport sink (
        input valid, input func_code, input payload_len, input byte_index,
        input byte_value, input has_byte, input sum_ok, input last,
        output ready
    );
endinterface

// File: hdl/slcf_ram.sv
// generic single-port-write, single-port-read synchronous ram
// registered read data; no dependencies

module slcf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/slcf_parser.sv
// byte-level frame parser: sync, function, length, payload and checksum phases
// writes payload bytes to the store; depends on slcf_pkg

module slcf_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  slcf_pkg::cfg_t              cfg,
    input  logic                        byte_valid,
    input  logic [slcf_pkg::BYTE_W-1:0] rx_byte,
    output slcf_pkg::ram_wr_t           ram_wr,
    output slcf_pkg::frame_start_t      start
);
    import slcf_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   func_reg, func_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    seen_reg, seen_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;

    logic [LIMIT_W-1:0]  lim_eff;
    logic                len_fits;
    logic                func_fits;
    logic [LEN_W-1:0]    seen_plus;
    logic [BYTE_W-1:0]   sum_plus;
    logic                sum_match;

    assign lim_eff   = (cfg.length_limit > LIMIT_CAP) ? LIMIT_CAP : cfg.length_limit;
    assign len_fits  = rx_byte < {1'b0, lim_eff};
    assign func_fits = (rx_byte != '0) && (rx_byte < FUNC_MAX_EXCL);
    assign seen_plus = seen_reg + LEN_W'(1);
    assign sum_plus  = sum_reg + rx_byte;
    assign sum_match = rx_byte == sum_reg;

    always_comb
    begin
        phase_next = phase_reg;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HUNT:  phase_next = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_HUNT;
                PH_SYNC2: phase_next = (rx_byte == cfg.sync_second) ? PH_FUNC : PH_HUNT;
                PH_FUNC:  phase_next = func_fits ? PH_LEN : PH_HUNT;
                PH_LEN:
                begin
                    if (!len_fits)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else if (rx_byte == '0)
                    begin
                        phase_next = PH_SUM;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:  phase_next = (seen_plus >= len_reg) ? PH_SUM : PH_DATA;
                PH_SUM:   phase_next = PH_HUNT;
                default:  phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb
    begin
        func_next     = func_reg;
        len_next      = len_reg;
        seen_next     = seen_reg;
        sum_next      = sum_reg;
        ram_wr.en     = 1'b0;
        ram_wr.addr   = seen_reg[ADDR_W-1:0];
        ram_wr.data   = rx_byte;
        start.valid   = 1'b0;
        start.flagged = !sum_match || (len_reg == '0);
        start.sum_ok  = sum_match;
        start.func    = func_reg;
        start.len     = len_reg;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    sum_next = rx_byte;
                end
                PH_SYNC2:
                begin
                    sum_next = sum_plus;
                end
                PH_FUNC:
                begin
                    if (func_fits)
                    begin
                        func_next = rx_byte;
                    end
                    sum_next = sum_plus;
                end
                PH_LEN:
                begin
                    if (len_fits)
                    begin
                        len_next  = rx_byte[LEN_W-1:0];
                        seen_next = '0;
                    end
                    sum_next = sum_plus;
                end
                PH_DATA:
                begin
                    ram_wr.en = 1'b1;
                    sum_next  = sum_plus;
                    seen_next = seen_plus;
                end
                PH_SUM:
                begin
                    start.valid = 1'b1;
                end
                default:
                begin
                    sum_next = sum_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            func_reg  <= '0;
            len_reg   <= '0;
            seen_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

// File: hdl/slcf_emitter.sv
// result sequencer: reads stored payload back and fills the output register
// one byte per read; depends on slcf_pkg

module slcf_emitter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  slcf_pkg::frame_start_t      start,
    output logic                        busy,
    output logic                        rd_en,
    output logic [slcf_pkg::ADDR_W-1:0] rd_addr,
    input  logic [slcf_pkg::BYTE_W-1:0] rd_data,
    input  logic                        out_ready,
    output logic                        out_valid,
    output slcf_pkg::result_t           out_res
);
    import slcf_pkg::*;

    emit_state_t        state_reg, state_next;
    logic [BYTE_W-1:0]  func_reg, func_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ok_reg, ok_next;
    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg, out_res_next;

    logic               out_free;
    logic               idx_last;

    assign out_free = !out_valid_reg || out_ready;
    assign idx_last = idx_reg == (len_reg - LEN_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (start.valid)
                begin
                    state_next = start.flagged ? EM_FLAG : EM_READ;
                end
            end
            EM_READ: state_next = out_free ? EM_LOAD : EM_READ;
            EM_LOAD: state_next = idx_last ? EM_IDLE : EM_READ;
            EM_FLAG: state_next = out_free ? EM_IDLE : EM_FLAG;
            default: state_next = EM_IDLE;
        endcase
    end

    always_comb
    begin
        busy    = state_reg != EM_IDLE;
        rd_en   = (state_reg == EM_READ) && out_free;
        rd_addr = idx_reg[ADDR_W-1:0];
    end

    always_comb
    begin
        func_next      = func_reg;
        len_next       = len_reg;
        ok_next        = ok_reg;
        idx_next       = idx_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if ((state_reg == EM_IDLE) && start.valid)
        begin
            func_next = start.func;
            len_next  = start.len;
            ok_next   = start.sum_ok;
            idx_next  = '0;
        end
        if (state_reg == EM_LOAD)
        begin
            out_valid_next           = 1'b1;
            out_res_next.func_code   = func_reg;
            out_res_next.payload_len = len_reg;
            out_res_next.byte_index  = idx_reg;
            out_res_next.byte_value  = rd_data;
            out_res_next.has_byte    = 1'b1;
            out_res_next.sum_ok      = 1'b1;
            out_res_next.last        = idx_last;
            idx_next                 = idx_reg + LEN_W'(1);
        end
        if ((state_reg == EM_FLAG) && out_free)
        begin
            out_valid_next           = 1'b1;
            out_res_next.func_code   = func_reg;
            out_res_next.payload_len = len_reg;
            out_res_next.byte_index  = '0;
            out_res_next.byte_value  = '0;
            out_res_next.has_byte    = 1'b0;
            out_res_next.sum_ok      = ok_reg;
            out_res_next.last        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        len_reg     <= len_next;
        ok_reg      <= ok_next;
        idx_reg     <= idx_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// File: hdl/sync_length_checksum_frame_receiver.sv
// top level of the sync/length/checksum frame receiver: apb registers,
// parser, payload store and result sequencer
// depends on slcf_pkg, slcf_in_if, slcf_out_if, slcf_ram, slcf_parser, slcf_emitter

// usage
// - in_ch carries received uart bytes; a byte transfers when valid and ready are high.
//   a byte is taken whenever the result sequencer is idle
// - frames: sync_first, sync_second, function code 1..240, length below length_limit
//   (capped at 64), payload, then an 8-bit sum of all earlier frame bytes
// - out_ch carries results; a good frame with payload gives one transfer per
//   payload byte, last set on the final one; a zero length or bad checksum frame
//   gives one transfer with has_byte low and last high
// - after the checksum byte, the sequencer reads each payload byte from the store
//   with a registered read and then loads it into the output register before the
//   next read; a flagged frame loads its one result without any read
// - in_ch.ready is low only while the result sequencer is busy: reading a frame
//   out of the store or waiting to load a flagged result; a last result still
//   waiting on out_ch does not block new bytes
// - when the receiver stalls, the output register holds its result and the
//   read-out pauses; no result is dropped
// - reset puts the parser back to hunting, restores the sync bytes and length
//   limit, and empties the output register; the store needs no clearing
// - configuration goes through apb; the user must write it only while idle, unchecked

module sync_length_checksum_frame_receiver (
    input  logic                        clk,
    input  logic                        rst_n,
    slcf_in_if.sink                     in_ch,
    slcf_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import slcf_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0]  sync_first_reg;
    logic [BYTE_W-1:0]  sync_second_reg;
    logic [LIMIT_W-1:0] length_limit_reg;
    logic               apb_write;
    cfg_t               cfg;

    // internal links
    ram_wr_t            ram_wr;
    frame_start_t       start;
    logic               emit_busy;
    logic               in_xfer;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [BYTE_W-1:0]  rd_data;
    logic               out_valid;
    result_t            out_res;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg   <= SYNC_FIRST_RST;
            sync_second_reg  <= SYNC_SECOND_RST;
            length_limit_reg <= LENGTH_LIMIT_RST;
        end
        else if (apb_write)
        begin
            unique case (paddr[3:2])
                REG_SYNC_FIRST:   sync_first_reg   <= pwdata[BYTE_W-1:0];
                REG_SYNC_SECOND:  sync_second_reg  <= pwdata[BYTE_W-1:0];
                REG_LENGTH_LIMIT: length_limit_reg <= pwdata[LIMIT_W-1:0];
                default:          sync_first_reg   <= sync_first_reg;
            endcase
        end
    end

    // read-back mux
    always_comb
    begin
        unique case (paddr[3:2])
            REG_SYNC_FIRST:   prdata = 32'(sync_first_reg);
            REG_SYNC_SECOND:  prdata = 32'(sync_second_reg);
            REG_LENGTH_LIMIT: prdata = 32'(length_limit_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.sync_first   = sync_first_reg;
    assign cfg.sync_second  = sync_second_reg;
    assign cfg.length_limit = length_limit_reg;

    // input is held off while the store is being read out, so a payload
    // write never meets a read of the same store
    assign in_ch.ready = !emit_busy;
    assign in_xfer     = in_ch.valid && !emit_busy;

    slcf_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (in_xfer),
        .rx_byte    (in_ch.rx_byte),
        .ram_wr     (ram_wr),
        .start      (start)
    );

    // payload store
    slcf_ram #(
        .DEPTH (PAYLOAD_DEPTH),
        .WIDTH (BYTE_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    slcf_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (emit_busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign out_ch.valid       = out_valid;
    assign out_ch.func_code   = out_res.func_code;
    assign out_ch.payload_len = out_res.payload_len;
    assign out_ch.byte_index  = out_res.byte_index;
    assign out_ch.byte_value  = out_res.byte_value;
    assign out_ch.has_byte    = out_res.has_byte;
    assign out_ch.sum_ok      = out_res.sum_ok;
    assign out_ch.last        = out_res.last;

`ifndef NO_ASSERTIONS
    // store write and read-out never overlap
    assert property (@(posedge clk) disable iff (!rst_n) ram_wr.en |-> !emit_busy)
        else $error("payload store written during read-out");

    // a checksum byte always starts the read-out sequencer
    assert property (@(posedge clk) disable iff (!rst_n) start.valid |=> emit_busy)
        else $error("checksum byte did not start read-out");

    // a result without a payload byte is always the only, final one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_res.has_byte) |-> out_res.last)
        else $error("flagged result not marked last");

    // payload bytes are only shown for frames with a good checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.has_byte) |-> out_res.sum_ok)
        else $error("payload byte from a bad frame");
`endif

endmodule
